// File: design/slg_pkg.sv
package slg_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] REG_RELAX = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;
  localparam logic [1:0] REG_SIZE  = 2'd3;

  localparam int unsigned ONE_Q16    = 65536;
  localparam logic [17:0] OMEGA_MAX  = 18'd131072;

  // Status from the sweep engine to the top level.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] sweeps;
    logic        met;
  } solve_status_t;

endpackage

// File: design/slg_update.sv
// One relaxation update: two multiplies into registers, then add, round and
// saturate in the following cycle. One register stage, one cell in flight.
module slg_update #(
  parameter int VALUE_BITS = 18
) (
  input  logic                         clk,
  input  logic                         start,
  input  logic signed [VALUE_BITS-1:0] old_value,
  input  logic signed [VALUE_BITS+1:0] nbr_sum,
  input  logic        [17:0]           omega,
  output logic signed [VALUE_BITS-1:0] new_value,
  output logic        [VALUE_BITS:0]   abs_change
);
  localparam int PW = VALUE_BITS + 22;
  localparam int NW = PW + 2;

  logic signed [PW-1:0] prod_old;
  logic signed [PW-1:0] prod_sum;
  logic signed [VALUE_BITS-1:0] old_q;
  logic signed [NW-1:0] num;
  logic signed [NW-1:0] rounded;
  logic signed [NW-1:0] hi_lim;
  logic signed [NW-1:0] lo_lim;
  logic signed [VALUE_BITS-1:0] sat_v;
  logic signed [VALUE_BITS:0] diff;
  logic signed [18:0] one_minus;

  assign one_minus = 19'sd65536 - $signed({1'b0, omega});

  always_ff @(posedge clk) begin
    if (start) begin
      prod_old <= PW'(one_minus * old_value) <<< 2;
      prod_sum <= PW'($signed({1'b0, omega}) * nbr_sum);
      old_q    <= old_value;
    end
  end

  assign num     = NW'(prod_old) + NW'(prod_sum) + NW'(1 << 17);
  assign rounded = num >>> 18;
  assign hi_lim  = NW'((1 <<< (VALUE_BITS - 1)) - 1);
  assign lo_lim  = -hi_lim - NW'(1);

  always_comb begin
    priority if (rounded > hi_lim) sat_v = hi_lim[VALUE_BITS-1:0];
    else if (rounded < lo_lim)     sat_v = lo_lim[VALUE_BITS-1:0];
    else                           sat_v = rounded[VALUE_BITS-1:0];
  end

  assign new_value  = sat_v;
  assign diff       = (VALUE_BITS+1)'(old_q) - (VALUE_BITS+1)'(sat_v);
  assign abs_change = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : diff;
endmodule

// File: design/slg_engine.sv
// Sweep sequencer: per cell reads center and four neighbors from the grid
// memory one per cycle, runs the shared update unit, writes back.
module slg_engine #(
  parameter int GRID_SIDE  = 64,
  parameter int VALUE_BITS = 18,
  parameter int AW = 2 * $clog2(GRID_SIDE),
  parameter int CW = $clog2(GRID_SIDE)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [17:0]                  omega,
  input  logic [15:0]                  tol,
  input  logic [15:0]                  limit,
  input  logic [CW:0]                  side,
  output logic [AW-1:0]                mem_addr,
  output logic                         mem_we,
  output logic signed [VALUE_BITS-1:0] mem_wdata,
  input  logic signed [VALUE_BITS-1:0] mem_rdata,
  input  logic                         mem_rfix,
  output slg_pkg::solve_status_t       status
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RC = 4'd1, S_RL = 4'd2, S_RR = 4'd3,
    S_RD = 4'd4, S_RU = 4'd5, S_ACC = 4'd6, S_MUL = 4'd7, S_WR = 4'd8,
    S_NEXT = 4'd9, S_END = 4'd10;

  logic [3:0] state;
  logic [CW-1:0] r, c;
  logic signed [VALUE_BITS-1:0] center;
  logic fixed;
  logic signed [VALUE_BITS+1:0] sum;
  logic [VALUE_BITS:0] maxd;
  logic [15:0] sweeps;
  logic met, done;
  logic upd_start;
  logic signed [VALUE_BITS-1:0] new_v;
  logic [VALUE_BITS:0] absd;
  logic [CW:0] last;

  assign last = side - (CW+1)'(2);

  slg_update #(.VALUE_BITS(VALUE_BITS)) u_upd (
    .clk, .start(upd_start), .old_value(center), .nbr_sum(sum), .omega,
    .new_value(new_v), .abs_change(absd));

  assign upd_start = (state == S_MUL);

  always_comb begin
    mem_addr = {r, c};
    unique case (state)
      S_RL: mem_addr = {r, c - CW'(1)};
      S_RR: mem_addr = {r, c + CW'(1)};
      S_RD: mem_addr = {r - CW'(1), c};
      S_RU: mem_addr = {r + CW'(1), c};
      default: mem_addr = {r, c};
    endcase
  end
  assign mem_we    = (state == S_WR) && !fixed;
  assign mem_wdata = new_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; sweeps <= '0; met <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          r <= CW'(1); c <= CW'(1); maxd <= '0; sweeps <= '0; met <= 1'b0;
          state <= S_RC;
        end
        S_RC: state <= S_RL;
        S_RL: begin
          center <= mem_rdata; fixed <= mem_rfix; state <= S_RR;
        end
        S_RR: begin sum <= (VALUE_BITS+2)'(mem_rdata); state <= S_RD; end
        S_RD: begin sum <= sum + (VALUE_BITS+2)'(mem_rdata); state <= S_RU; end
        S_RU: begin sum <= sum + (VALUE_BITS+2)'(mem_rdata); state <= S_ACC; end
        S_ACC: begin sum <= sum + (VALUE_BITS+2)'(mem_rdata); state <= S_MUL; end
        S_MUL: state <= S_WR;
        S_WR: begin
          if (!fixed && absd > maxd) maxd <= absd;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if ((CW+1)'(c) == last) begin
            c <= CW'(1);
            if ((CW+1)'(r) == last) state <= S_END;
            else begin r <= r + CW'(1); state <= S_RC; end
          end else begin
            c <= c + CW'(1); state <= S_RC;
          end
        end
        S_END: begin
          sweeps <= sweeps + 16'd1;
          r <= CW'(1); c <= CW'(1); maxd <= '0;
          if (maxd <= (VALUE_BITS+1)'(tol)) begin
            met <= 1'b1; done <= 1'b1; state <= S_IDLE;
          end else if (sweeps + 16'd1 >= limit) begin
            done <= 1'b1; state <= S_IDLE;
          end else state <= S_RC;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.busy   = (state != S_IDLE);
  assign status.done   = done;
  assign status.sweeps = sweeps;
  assign status.met    = met;
endmodule

// File: design/sor_laplace_grid_solver_top.sv
// SOR Laplace solver over a GRID_SIDE square of signed Q1.16 cells held in
// one single-port grid memory (value plus fixed flag). Op 0 loads a cell and
// op 2 reads one back; each passes through accept, memory access and a
// registered result. Op 1 runs a full solve: every interior cell passes
// through five sequential reads of the single memory port, a step to close
// the neighbor sum, the registered multiply stage of the shared update
// unit, the write back and the step to the next cell. in_ready stays low
// while any transaction is in progress. Every transaction returns one
// result: read_value (zero except for in-grid reads), plus the sweep count
// and converged flag of the last solve. Configuration writes (omega,
// tolerance, sweep limit, active side) are not latched at solve start; the
// engine reads them live, so a write during a solve acts at once.
module sor_laplace_grid_solver_top #(
  parameter int GRID_SIDE  = 64,
  parameter int VALUE_BITS = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [5:0]         col,
  input  logic [5:0]         row,
  input  logic signed [17:0] cell_value,
  input  logic               held,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] read_value,
  output logic [15:0]        sweeps_done,
  output logic               converged
);
  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [1:0] T_IDLE = 2'd0, T_MEM = 2'd1, T_SOLVE = 2'd2, T_OUT = 2'd3;

  logic [17:0] relax_factor;
  logic [15:0] tolerance;
  logic [15:0] sweep_limit;
  logic [6:0]  active_size;

  logic signed [VALUE_BITS-1:0] grid_mem [DEPTH];
  logic                         fix_mem  [DEPTH];
  logic signed [VALUE_BITS-1:0] rdata;
  logic                         rfix;

  logic [1:0] tstate;
  logic [1:0] op_q;
  logic       in_grid_q;
  logic [AW-1:0] addr_q;
  logic signed [VALUE_BITS-1:0] wval_q;
  logic held_q;

  logic [AW-1:0] eng_addr;
  logic eng_we;
  logic signed [VALUE_BITS-1:0] eng_wdata;
  slg_pkg::solve_status_t st;
  logic eng_start;

  logic [AW-1:0] mem_addr;
  logic mem_we;
  logic signed [VALUE_BITS-1:0] mem_wdata;
  logic mem_wfix;

  logic [17:0] omega_eff;
  logic [15:0] limit_eff;
  logic [CW:0] side_eff;
  logic signed [VALUE_BITS-1:0] sat_in;
  logic signed [17:0] sat_out;
  logic in_grid;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      relax_factor <= 18'd98304; tolerance <= 16'd1;
      sweep_limit <= 16'd10000; active_size <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slg_pkg::REG_RELAX: relax_factor <= cfg_data;
        slg_pkg::REG_TOL:   tolerance    <= cfg_data[15:0];
        slg_pkg::REG_LIMIT: sweep_limit  <= cfg_data[15:0];
        slg_pkg::REG_SIZE:  active_size  <= cfg_data[6:0];
      endcase
    end
  end

  // Clamp omega, the sweep limit and the active side into their legal ranges.
  assign omega_eff = (relax_factor > slg_pkg::OMEGA_MAX) ? slg_pkg::OMEGA_MAX : relax_factor;
  assign limit_eff = (sweep_limit == 16'd0) ? 16'd1 : sweep_limit;
  always_comb begin
    priority if (active_size < 7'd3) side_eff = (CW+1)'(3);
    else if (32'(active_size) > GRID_SIDE) side_eff = (CW+1)'(GRID_SIDE);
    else side_eff = (CW+1)'(active_size);
  end

  // Saturate a loaded value into storage width.
  always_comb begin
    if (VALUE_BITS >= 18) sat_in = VALUE_BITS'(cell_value);
    else if (32'(cell_value) > (2 ** (VALUE_BITS - 1)) - 1)
      sat_in = VALUE_BITS'((2 ** (VALUE_BITS - 1)) - 1);
    else if (32'(cell_value) < -(2 ** (VALUE_BITS - 1)))
      sat_in = VALUE_BITS'(-(2 ** (VALUE_BITS - 1)));
    else sat_in = VALUE_BITS'(cell_value);
  end

  // Saturate a stored value to the 18-bit output field.
  always_comb begin
    if (VALUE_BITS <= 18) sat_out = 18'(rdata);
    else if (rdata > (VALUE_BITS)'(131071)) sat_out = 18'sd131071;
    else if (rdata < -(VALUE_BITS)'(131072)) sat_out = -18'sd131072;
    else sat_out = 18'(rdata);
  end

  assign in_grid = (32'(row) < GRID_SIDE) && (32'(col) < GRID_SIDE);

  slg_engine #(.GRID_SIDE(GRID_SIDE), .VALUE_BITS(VALUE_BITS)) u_eng (
    .clk, .rst, .start(eng_start), .omega(omega_eff), .tol(tolerance),
    .limit(limit_eff), .side(side_eff), .mem_addr(eng_addr), .mem_we(eng_we),
    .mem_wdata(eng_wdata), .mem_rdata(rdata), .mem_rfix(rfix), .status(st));

  assign eng_start = (tstate == T_MEM) && (op_q == slg_pkg::OP_SOLVE);

  // Mux the single grid port between the host and the sweep engine.
  always_comb begin
    if (tstate == T_SOLVE) begin
      mem_addr = eng_addr; mem_we = eng_we; mem_wdata = eng_wdata; mem_wfix = 1'b0;
    end else begin
      mem_addr  = addr_q;
      mem_we    = (tstate == T_MEM) && (op_q == slg_pkg::OP_LOAD) && in_grid_q;
      mem_wdata = wval_q; mem_wfix = held_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
      if (tstate != T_SOLVE) fix_mem[mem_addr] <= mem_wfix;
    end
    rdata <= grid_mem[mem_addr];
    rfix  <= fix_mem[mem_addr];
  end

  // Transaction sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= T_IDLE; out_valid <= 1'b0;
    end else begin
      unique case (tstate)
        T_IDLE: if (in_valid) begin
          op_q <= op; in_grid_q <= in_grid; addr_q <= {CW'(row), CW'(col)};
          wval_q <= sat_in; held_q <= held; tstate <= T_MEM;
        end
        T_MEM: tstate <= (op_q == slg_pkg::OP_SOLVE) ? T_SOLVE : T_OUT;
        T_SOLVE: if (st.done) tstate <= T_OUT;
        T_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          read_value <= (op_q == slg_pkg::OP_READ && in_grid_q) ? sat_out : '0;
          sweeps_done <= st.sweeps; converged <= st.met;
        end else if (out_ready) begin
          out_valid <= 1'b0; tstate <= T_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (tstate == T_IDLE);
endmodule

// File: design/slg_checker.sv
module slg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] sweeps_done,
  input logic converged
);
  // No new transaction while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // Result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sweeps_done))
    else $error("result dropped");
  // A converged solve reports at least one sweep.
  a_conv: assert property (@(posedge clk) disable iff (rst)
    out_valid && converged |-> sweeps_done != 16'd0) else $error("bad count");
  // Accept leads to busy next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind sor_laplace_grid_solver_top slg_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sweeps_done, .converged);
